>>> rtl/core/rcr_pkg.sv
// Shared constants for the result cache: codes, field widths, parameter defaults.
`default_nettype none
package rcr_pkg;
    localparam int ENTRIES_DEF     = 16;
    localparam int EVICT_COUNT_DEF = 4;
    localparam int KEY_BITS_DEF    = 64;

    localparam int CMD_W   = 2;
    localparam int TAG_W   = 64;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 16;
    localparam int EVC_W   = 5;
    localparam int SEED_W  = 16;
    localparam int S_DATA_W = 88;   // 82 payload bits padded to bytes
    localparam int M_DATA_W = 24;   // 23 payload bits padded to bytes
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_FEWEST = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd1;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
endpackage
`default_nettype wire

>>> rtl/core/rcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/result_cache_with_replacement_top.sv
// Top level of the fully associative result cache with selectable eviction.
// Commands: clear empties the cache; lookup/get search entries in order until a key match;
// an insert searches too and, on a miss with room, writes the new entry at the end.
// A full insert first evicts entries, shifting later entries down over each victim; victim pick:
// fewest hits scans all entries, random a bit-serial modulo of the LFSR, oldest entry 0.
// Reset (rst_n low, async): cache empty, policy oldest first, seed and LFSR 1.
`default_nettype none
module result_cache_with_replacement_top #(
    parameter int ENTRIES     = rcr_pkg::ENTRIES_DEF,
    parameter int EVICT_COUNT = rcr_pkg::EVICT_COUNT_DEF,
    parameter int KEY_BITS    = rcr_pkg::KEY_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command[1:0], key_tag[65:2], data_value[81:66], zero pad
    input  wire logic [rcr_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // hit[0], read_value[16:1], status[17], evicted_count[22:18], zero pad
    output logic      [rcr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rcr_pkg::SEED_W-1:0]    cfg_data
);
    import rcr_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int EV_W   = $clog2(EVICT_COUNT + 1);
    localparam int WORD_W = KEY_BITS + VAL_W + CNT_W;
    localparam int MODB_W = $clog2(SEED_W);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SRD    = 4'd1;   // search: issue read
    localparam logic [3:0] ST_SCMP   = 4'd2;   // search: compare key
    localparam logic [3:0] ST_EVSEL  = 4'd3;   // pick next eviction
    localparam logic [3:0] ST_MINRD  = 4'd4;
    localparam logic [3:0] ST_MINCMP = 4'd5;
    localparam logic [3:0] ST_MOD    = 4'd6;   // lfsr mod occupancy
    localparam logic [3:0] ST_MVRD   = 4'd7;   // compaction: read next
    localparam logic [3:0] ST_MVWR   = 4'd8;   // compaction: write down
    localparam logic [3:0] ST_INS    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam logic [OCC_W-1:0] FULL = OCC_W'(ENTRIES);
    localparam logic [EV_W-1:0]  EV_MAX = EV_W'(EVICT_COUNT);

    logic [3:0]          state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VAL_W-1:0]    data_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    ptr_reg;
    logic [OCC_W-1:0]    best_reg;
    logic [CNT_W-1:0]    best_cnt_reg;
    logic [EV_W-1:0]     n_reg;
    logic [1:0]          policy_reg;
    logic [SEED_W-1:0]   lfsr_reg;
    logic [SEED_W-1:0]   mod_sh_reg;
    logic [OCC_W:0]      rem_reg;
    logic [MODB_W-1:0]   modb_reg;
    logic                res_hit_reg, res_status_reg;
    logic [VAL_W-1:0]    res_value_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;
    logic [KEY_BITS-1:0] rd_key;
    logic [VAL_W-1:0]    rd_value;
    logic [CNT_W-1:0]    rd_cnt;
    logic [OCC_W-1:0]    ptr_inc;
    logic [OCC_W:0]      rem_try;
    logic [OCC_W:0]      rem_new;
    logic [SEED_W-1:0]   lfsr_step;
    logic                s_fire, out_free;

    assign rd_key   = ram_rdata[KEY_BITS-1:0];
    assign rd_value = ram_rdata[KEY_BITS +: VAL_W];
    assign rd_cnt   = ram_rdata[KEY_BITS+VAL_W +: CNT_W];
    assign ptr_inc  = ptr_reg + OCC_W'(1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Galois step, right shift
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    // restoring modulo, one dividend bit per cycle
    assign rem_try = {rem_reg[OCC_W-1:0], mod_sh_reg[SEED_W-1]};
    assign rem_new = (rem_try >= {1'b0, occ_reg}) ? (rem_try - {1'b0, occ_reg}) : rem_try;

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = ptr_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_SCMP:
            begin
                if (rd_key == key_reg && cmd_reg == CMD_GET && rd_cnt != {CNT_W{1'b1}})
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {rd_cnt + CNT_W'(1), rd_value, rd_key};
                end
            end
            ST_MVRD:
            begin
                ram_raddr = ptr_inc[IDX_W-1:0];
            end
            ST_MVWR:
            begin
                ram_we = 1'b1;
            end
            ST_INS:
            begin
                ram_we    = (occ_reg < FULL);
                ram_waddr = occ_reg[IDX_W-1:0];
                ram_wdata = {CNT_W'(0), data_reg, key_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire) state_next = (s_tdata[CMD_W-1:0] == CMD_CLEAR) ? ST_OUT : ST_SRD;
            ST_SRD:
            begin
                if (ptr_reg >= occ_reg)
                begin
                    if (cmd_reg == CMD_INSERT)
                        state_next = (occ_reg >= FULL) ? ST_EVSEL : ST_INS;
                    else
                        state_next = ST_OUT;
                end
                else
                    state_next = ST_SCMP;
            end
            ST_SCMP:   state_next = (rd_key == key_reg) ? ST_OUT : ST_SRD;
            ST_EVSEL:
            begin
                if (n_reg == EV_MAX || occ_reg == '0)
                    state_next = ST_INS;
                else if (policy_reg == POL_FEWEST)
                    state_next = ST_MINRD;
                else if (policy_reg == POL_RANDOM)
                    state_next = ST_MOD;
                else
                    state_next = ST_MVRD;
            end
            ST_MINRD:  state_next = (ptr_reg >= occ_reg) ? ST_MVRD : ST_MINCMP;
            ST_MINCMP: state_next = ST_MINRD;
            ST_MOD:    if (modb_reg == MODB_W'(SEED_W - 1)) state_next = ST_MVRD;
            ST_MVRD:   state_next = (ptr_inc >= occ_reg) ? ST_EVSEL : ST_MVWR;
            ST_MVWR:   state_next = ST_MVRD;
            ST_INS:    state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            policy_reg  <= POL_FIFO;
            lfsr_reg    <= SEED_W'(1);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index == REG_POLICY)
                policy_reg <= cfg_data[1:0];
            if (cfg_valid && cfg_index == REG_SEED)
                lfsr_reg <= cfg_data;
            else if (state_reg == ST_EVSEL && state_next == ST_MOD)
                lfsr_reg <= lfsr_step;

            if (s_fire && s_tdata[CMD_W-1:0] == CMD_CLEAR)
                occ_reg <= '0;
            else if (state_reg == ST_MVRD && ptr_inc >= occ_reg)
                occ_reg <= occ_reg - OCC_W'(1);
            else if (state_reg == ST_INS && occ_reg < FULL)
                occ_reg <= occ_reg + OCC_W'(1);

            if (state_reg == ST_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_reg        <= s_tdata[CMD_W-1:0];
                key_reg        <= s_tdata[CMD_W +: KEY_BITS];
                data_reg       <= s_tdata[CMD_W+TAG_W +: VAL_W];
                ptr_reg        <= '0;
                n_reg          <= '0;
                res_hit_reg    <= 1'b0;
                res_status_reg <= 1'b0;
                res_value_reg  <= '0;
            end
            ST_SRD:
            begin
                if (ptr_reg >= occ_reg && cmd_reg == CMD_GET)
                    res_status_reg <= 1'b1;
            end
            ST_SCMP:
            begin
                if (rd_key == key_reg)
                begin
                    res_hit_reg <= 1'b1;
                    if (cmd_reg == CMD_GET)
                        res_value_reg <= rd_value;
                end
                else
                    ptr_reg <= ptr_inc;
            end
            ST_EVSEL:
            begin
                ptr_reg    <= '0;
                rem_reg    <= '0;
                modb_reg   <= '0;
                mod_sh_reg <= lfsr_step;
            end
            ST_MINRD:
            begin
                if (ptr_reg >= occ_reg)
                    ptr_reg <= best_reg;
            end
            ST_MINCMP:
            begin
                if (ptr_reg == '0 || rd_cnt < best_cnt_reg)
                begin
                    best_reg     <= ptr_reg;
                    best_cnt_reg <= rd_cnt;
                end
                ptr_reg <= ptr_inc;
            end
            ST_MOD:
            begin
                rem_reg    <= rem_new;
                mod_sh_reg <= mod_sh_reg << 1;
                modb_reg   <= modb_reg + MODB_W'(1);
                ptr_reg    <= rem_new[OCC_W-1:0];
            end
            ST_MVRD:
            begin
                if (ptr_inc >= occ_reg)
                    n_reg <= n_reg + EV_W'(1);
            end
            ST_MVWR:
            begin
                ptr_reg <= ptr_inc;
            end
            ST_OUT:
            begin
                if (out_free)
                    m_data_reg <= {1'b0, EVC_W'(n_reg), res_status_reg, res_value_reg,
                                   res_hit_reg};
            end
            default:
            begin
            end
        endcase
    end

    rcr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL) else $error("occupancy above capacity");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tdata[CMD_W-1:0] == CMD_CLEAR |=> occ_reg == '0)
        else $error("clear left entries");
    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MVRD |-> ptr_reg < occ_reg) else $error("victim out of range");
    a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> m_data_reg[22:18] <= EVC_W'(EVICT_COUNT))
        else $error("too many evictions");
`endif
endmodule
`default_nettype wire
